// ===== hdl/dce_pkg.sv =====
`timescale 1ns / 1ps

package dce_pkg;

  localparam int unsigned DW = 24;   // data path width
  localparam int unsigned OW = 16;   // instruction word width
  localparam int unsigned PW = 16;   // page register width

  // Flag positions inside the packed flag word
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  localparam logic [DW-1:0] SHIFT_LIMIT = 24'd23;

  // Decode masks
  localparam logic [OW-1:0] MASK_GRP  = 16'hfc00;
  localparam logic [OW-1:0] MASK_JMP  = 16'hdd00;
  localparam logic [OW-1:0] MASK_ALU  = 16'hf800;
  localparam logic [OW-1:0] MASK_IMM  = 16'hfb00;
  localparam logic [OW-1:0] MASK_BYTE = 16'hff00;

  // Opcode patterns
  localparam logic [OW-1:0] PAT_NOP   = 16'h0000;
  localparam logic [OW-1:0] PAT_JMP   = 16'h0800;
  localparam logic [OW-1:0] PAT_JZ    = 16'h0c00;
  localparam logic [OW-1:0] PAT_JC    = 16'h1000;
  localparam logic [OW-1:0] PAT_JN    = 16'h1400;
  localparam logic [OW-1:0] PAT_JV    = 16'h1800;
  localparam logic [OW-1:0] PAT_LOOP  = 16'h1c00;
  localparam logic [OW-1:0] PAT_SKIP  = 16'h2400;
  localparam logic [OW-1:0] PAT_RET   = 16'h3c00;
  localparam logic [OW-1:0] PAT_INC   = 16'h4000;
  localparam logic [OW-1:0] PAT_CMPR  = 16'h4800;
  localparam logic [OW-1:0] PAT_CMP   = 16'h5000;
  localparam logic [OW-1:0] PAT_SXB   = 16'h5900;
  localparam logic [OW-1:0] PAT_SXW   = 16'h5a00;
  localparam logic [OW-1:0] PAT_LD    = 16'h6000;
  localparam logic [OW-1:0] PAT_LDP   = 16'h6300;
  localparam logic [OW-1:0] PAT_PGLO  = 16'h7c00;
  localparam logic [OW-1:0] PAT_PGHI  = 16'h7d00;
  localparam logic [OW-1:0] PAT_ADD   = 16'h8000;
  localparam logic [OW-1:0] PAT_SUBR  = 16'h8800;
  localparam logic [OW-1:0] PAT_SUB   = 16'h9000;
  localparam logic [OW-1:0] PAT_MUL   = 16'h9800;
  localparam logic [OW-1:0] PAT_XOR   = 16'ha800;
  localparam logic [OW-1:0] PAT_AND   = 16'hb000;
  localparam logic [OW-1:0] PAT_OR    = 16'hb800;
  localparam logic [OW-1:0] PAT_SHR   = 16'hc000;
  localparam logic [OW-1:0] PAT_ASR   = 16'hc800;
  localparam logic [OW-1:0] PAT_ROR   = 16'hd000;
  localparam logic [OW-1:0] PAT_SHL   = 16'hd800;
  localparam logic [OW-1:0] PAT_ST    = 16'he000;
  localparam logic [OW-1:0] PAT_SWAP  = 16'hf000;
  localparam logic [OW-1:0] PAT_CLR   = 16'hf800;
  // External bus, RAM and ROM transfers (no effect inside this unit)
  localparam logic [OW-1:0] PAT_EXT_A = 16'h6100;
  localparam logic [OW-1:0] PAT_EXT_B = 16'h6800;
  localparam logic [OW-1:0] PAT_EXT_C = 16'h6900;
  localparam logic [OW-1:0] PAT_EXT_D = 16'h6a00;
  localparam logic [OW-1:0] PAT_EXT_E = 16'h7000;
  localparam logic [OW-1:0] PAT_EXT_F = 16'he100;
  localparam logic [OW-1:0] PAT_EXT_G = 16'he800;
  localparam logic [OW-1:0] PAT_EXT_H = 16'he900;
  localparam logic [OW-1:0] PAT_EXT_I = 16'hea00;

  typedef logic [3:0] flags_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_JMP, OP_SKIP, OP_RET, OP_CMPR, OP_CMP, OP_SXB, OP_SXW, OP_LD,
    OP_LDP, OP_PGLO, OP_PGHI, OP_ADD, OP_SUBR, OP_SUB, OP_MUL, OP_XOR, OP_AND,
    OP_OR, OP_SHR, OP_ASR, OP_ROR, OP_SHL, OP_ST, OP_SWAP, OP_CLR, OP_HALT
  } op_class_t;

  typedef struct packed {
    logic [DW-1:0]   acc;
    flags_t          flags;
    logic            prod_we;
    logic [2*DW-1:0] prod;
  } alu_res_t;

  typedef struct packed {
    logic          push;
    logic          pop;
    logic [DW-1:0] data;
  } stk_ctl_t;

endpackage

// ===== hdl/dce_alu.sv =====
`timescale 1ns / 1ps

module dce_alu import dce_pkg::*; (
  input  op_class_t     op_class,
  input  logic [OW-1:0] opcode,
  input  logic [DW-1:0] ri,
  input  logic [DW-1:0] acc,
  input  flags_t        flags,
  output alu_res_t      res
);

  // Residue mod 3 of a 21-bit value: hex digits, then base-4 digits, fold.
  function automatic logic [1:0] mod3_21(input logic [20:0] v);
    logic [23:0] p;
    logic [6:0]  s;
    logic [3:0]  t;
    logic [2:0]  u;
    p = {3'b000, v};
    s = 7'(p[3:0]) + 7'(p[7:4]) + 7'(p[11:8]) + 7'(p[15:12])
      + 7'(p[19:16]) + 7'(p[23:20]);
    t = 4'(s[6]) + 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    u = 3'(t[3:2]) + 3'(t[1:0]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  logic [DW-1:0]          sa;
  logic [DW-1:0]          x, y, diff, logic_r, shr_r, asr_r, rot_r, shl_r;
  logic [DW:0]            sum;
  logic                   big_sh;
  logic [4:0]             sh_amt, rot_amt;
  logic [2*DW-1:0]        rot_w;
  logic signed [2*DW-1:0] prod_s;

  always_comb begin
    case (opcode[9:8])
      2'd0:    sa = acc;
      2'd1:    sa = {acc[DW-2:0], 1'b0};
      2'd2:    sa = {acc[DW-9:0], 8'h00};
      default: sa = {acc[DW-17:0], 16'h0000};
    endcase
  end

  // Reversed forms put ri on the left
  assign x    = (op_class == OP_CMPR || op_class == OP_SUBR) ? ri : sa;
  assign y    = (op_class == OP_CMPR || op_class == OP_SUBR) ? sa : ri;
  assign diff = x - y;
  assign sum  = {1'b0, sa} + {1'b0, ri};

  assign big_sh  = ri > SHIFT_LIMIT;
  assign sh_amt  = ri[4:0];
  assign rot_amt = {mod3_21(ri[DW-1:3]), ri[2:0]};
  assign rot_w   = {acc, acc} >> rot_amt;
  assign shr_r   = big_sh ? '0 : acc >> sh_amt;
  assign shl_r   = big_sh ? '0 : acc << sh_amt;
  assign asr_r   = big_sh ? {DW{acc[DW-1]}} : DW'($signed(acc) >>> sh_amt);
  assign rot_r   = rot_w[DW-1:0];

  assign prod_s = $signed(acc) * $signed(ri);

  always_comb begin
    case (op_class)
      OP_XOR:  logic_r = sa ^ ri;
      OP_AND:  logic_r = sa & ri;
      default: logic_r = sa | ri;
    endcase
  end

  always_comb begin
    res.acc     = acc;
    res.flags   = flags;
    res.prod_we = 1'b0;
    res.prod    = prod_s;
    unique case (op_class)
      OP_CMPR, OP_CMP: begin
        res.flags[FLAG_N] = diff[DW-1];
        res.flags[FLAG_Z] = diff == '0;
        res.flags[FLAG_C] = x >= y;
      end
      OP_SXB:  res.acc = {{(DW-8){ri[7]}}, ri[7:0]};
      OP_SXW:  res.acc = {{(DW-16){ri[15]}}, ri[15:0]};
      OP_LD:   res.acc = ri;
      OP_ADD: begin
        res.acc           = sum[DW-1:0];
        res.flags[FLAG_N] = sum[DW-1];
        res.flags[FLAG_Z] = sum[DW-1:0] == '0;
        res.flags[FLAG_C] = sum[DW];
        res.flags[FLAG_V] = ~(sa[DW-1] & ri[DW-1]) & (sa[DW-1] ^ sum[DW-1]);
      end
      OP_SUBR, OP_SUB: begin
        res.acc           = diff;
        res.flags[FLAG_N] = diff[DW-1];
        res.flags[FLAG_Z] = diff == '0;
        res.flags[FLAG_C] = x >= y;
        res.flags[FLAG_V] = ~(x[DW-1] & y[DW-1]) & (x[DW-1] ^ diff[DW-1]);
      end
      OP_MUL: begin
        // Sign and zero follow from the factors; the product never overflows
        res.prod_we       = 1'b1;
        res.flags[FLAG_Z] = (acc == '0) || (ri == '0);
        res.flags[FLAG_N] = (acc[DW-1] ^ ri[DW-1]) && (acc != '0) && (ri != '0);
      end
      OP_XOR, OP_AND, OP_OR: begin
        res.acc           = logic_r;
        res.flags[FLAG_N] = logic_r[DW-1];
        res.flags[FLAG_Z] = logic_r == '0;
      end
      OP_SHR, OP_ASR, OP_ROR, OP_SHL: begin
        case (op_class)
          OP_SHR:  res.acc = shr_r;
          OP_ASR:  res.acc = asr_r;
          OP_ROR:  res.acc = rot_r;
          default: res.acc = shl_r;
        endcase
        res.flags[FLAG_N] = res.acc[DW-1];
        res.flags[FLAG_Z] = res.acc == '0;
      end
      default: begin
        res.acc = acc;
      end
    endcase
  end

endmodule

// ===== hdl/dce_stack.sv =====
`timescale 1ns / 1ps

module dce_stack import dce_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_ctl_t      ctl,
  output logic [DW-1:0] top_data
);

  logic [DW-1:0] stk_r [DEPTH];

  // Push drops the oldest entry; pop refills the bottom with zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        stk_r[i] <= '0;
      end
    end else if (ctl.push) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        stk_r[i] <= stk_r[i-1];
      end
      stk_r[0] <= ctl.data;
    end else if (ctl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
      stk_r[DEPTH-1] <= '0;
    end
  end

  assign top_data = stk_r[0];

endmodule

// ===== hdl/dsp_coprocessor_execute_unit_top.sv =====
// Execute stage of a 24-bit signal-processing coprocessor. Each input word
// carries a 16-bit instruction, the value of the register it names and the
// PC after fetch; each output word reports the accumulator, flags, product,
// page register, the PC to continue from, the taken/skip/halt status and a
// register write request. Throughput is one instruction per clock unless
// out_ready stalls; an input register feeds one execute pass (decode,
// shifted-A ALU, shifter, 24x24 signed multiplier, return stack) that lands
// in the architectural state and the output register together. The
// accumulator and flags loop back from that state into the next instruction
// in the input register, and this loop sets the rate. Unknown opcodes halt;
// halted stays set until reset, but instructions keep executing.
`timescale 1ns / 1ps

module dsp_coprocessor_execute_unit_top import dce_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_opcode,
  input  logic [23:0]   in_operand_value,
  input  logic [23:0]   in_fetched_pc,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [23:0]   out_acc_value,
  output logic [3:0]    out_flag_bits,
  output logic [23:0]   out_product_low,
  output logic [23:0]   out_product_high,
  output logic [15:0]   out_page_value,
  output logic [23:0]   out_new_pc,
  output logic          out_page_changed,
  output logic          out_skip_next,
  output logic          out_halted,
  output logic          out_write_valid,
  output logic [23:0]   out_write_data
);

  function automatic op_class_t decode(input logic [OW-1:0] op);
    logic [OW-1:0] g, j, a, m, b;
    g = op & MASK_GRP;
    j = op & MASK_JMP;
    a = op & MASK_ALU;
    m = op & MASK_IMM;
    b = op & MASK_BYTE;
    if (g == PAT_NOP)                                          return OP_NOP;
    else if (j == PAT_JMP || j == PAT_JZ || j == PAT_JC ||
             j == PAT_JN || j == PAT_JV)                       return OP_JMP;
    else if (g == PAT_LOOP)                                    return OP_NOP;
    else if (g == PAT_SKIP)                                    return OP_SKIP;
    else if (g == PAT_RET)                                     return OP_RET;
    else if (g == PAT_INC)                                     return OP_NOP;
    else if (a == PAT_CMPR)                                    return OP_CMPR;
    else if (a == PAT_CMP)                                     return OP_CMP;
    else if (m == PAT_SXB)                                     return OP_SXB;
    else if (m == PAT_SXW)                                     return OP_SXW;
    else if (m == PAT_LD)                                      return OP_LD;
    else if (m == PAT_LDP)                                     return OP_LDP;
    else if (b == PAT_PGLO)                                    return OP_PGLO;
    else if (b == PAT_PGHI)                                    return OP_PGHI;
    else if (a == PAT_ADD)                                     return OP_ADD;
    else if (a == PAT_SUBR)                                    return OP_SUBR;
    else if (a == PAT_SUB)                                     return OP_SUB;
    else if (m == PAT_MUL)                                     return OP_MUL;
    else if (a == PAT_XOR)                                     return OP_XOR;
    else if (a == PAT_AND)                                     return OP_AND;
    else if (a == PAT_OR)                                      return OP_OR;
    else if (m == PAT_SHR)                                     return OP_SHR;
    else if (m == PAT_ASR)                                     return OP_ASR;
    else if (m == PAT_ROR)                                     return OP_ROR;
    else if (m == PAT_SHL)                                     return OP_SHL;
    else if (b == PAT_ST)                                      return OP_ST;
    else if (g == PAT_SWAP)                                    return OP_SWAP;
    else if (g == PAT_CLR)                                     return OP_CLR;
    else if (m == PAT_EXT_A || m == PAT_EXT_B || m == PAT_EXT_C ||
             m == PAT_EXT_D || op == PAT_EXT_E || b == PAT_EXT_F ||
             m == PAT_EXT_G || m == PAT_EXT_H || m == PAT_EXT_I) return OP_NOP;
    else                                                       return OP_HALT;
  endfunction

  // Input register
  logic          s1_valid_r;
  logic [OW-1:0] s1_opcode_r;
  logic [DW-1:0] s1_operand_r;
  logic [DW-1:0] s1_pc_r;

  // Architectural state; it also serves as the output register for its fields
  logic [DW-1:0] acc_r, acc_nxt;
  flags_t        flags_r, flags_nxt;
  logic [DW-1:0] prod_lo_r, prod_hi_r;
  logic [PW-1:0] page_r, page_nxt;
  logic          halt_r, halt_nxt;

  // Per-instruction result fields
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] new_pc_r, new_pc_nxt;
  logic          taken_r, taken_nxt;
  logic          skip_r, skip_nxt;
  logic          wv_r, wv_nxt;
  logic [DW-1:0] wdata_r, wdata_nxt;

  logic          adv;
  op_class_t     op_class;
  logic [DW-1:0] ri;
  logic          jcond;
  logic [OW-1:0] jsel;
  alu_res_t      alu_res;
  stk_ctl_t      stk_ctl;
  logic [DW-1:0] stk_top;

  // Advance the execute pass whenever the output register is free or drains
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode_r  <= in_opcode;
      s1_operand_r <= in_operand_value;
      s1_pc_r      <= in_fetched_pc;
    end
  end

  assign op_class = decode(s1_opcode_r);
  assign ri       = s1_opcode_r[10] ? {{(DW-8){1'b0}}, s1_opcode_r[7:0]} : s1_operand_r;
  assign jsel     = s1_opcode_r & MASK_JMP;

  always_comb begin
    case (jsel)
      PAT_JZ:  jcond = flags_r[FLAG_Z];
      PAT_JC:  jcond = flags_r[FLAG_C];
      PAT_JN:  jcond = flags_r[FLAG_N];
      PAT_JV:  jcond = flags_r[FLAG_V];
      default: jcond = 1'b1;
    endcase
  end

  dce_alu u_alu (
    .op_class (op_class),
    .opcode   (s1_opcode_r),
    .ri       (ri),
    .acc      (acc_r),
    .flags    (flags_r),
    .res      (alu_res)
  );

  always_comb begin
    acc_nxt      = alu_res.acc;
    flags_nxt    = alu_res.flags;
    page_nxt     = page_r;
    halt_nxt     = halt_r;
    new_pc_nxt   = s1_pc_r;
    taken_nxt    = 1'b0;
    skip_nxt     = 1'b0;
    wv_nxt       = 1'b0;
    wdata_nxt    = '0;
    stk_ctl.push = 1'b0;
    stk_ctl.pop  = 1'b0;
    stk_ctl.data = s1_pc_r;
    unique case (op_class)
      OP_JMP: begin
        if (jcond) begin
          stk_ctl.push = s1_opcode_r[13];
          taken_nxt    = 1'b1;
          if (s1_opcode_r[9]) begin
            new_pc_nxt = {page_r, s1_opcode_r[7:0]};
          end else begin
            new_pc_nxt = {s1_pc_r[DW-1:8], s1_opcode_r[7:0]};
          end
        end
      end
      OP_SKIP: skip_nxt = flags_r[s1_opcode_r[9:8]] == s1_opcode_r[0];
      OP_RET: begin
        stk_ctl.pop = 1'b1;
        new_pc_nxt  = stk_top;
        taken_nxt   = 1'b1;
      end
      OP_LDP:  page_nxt = ri[PW-1:0];
      OP_PGLO: page_nxt = {page_r[PW-1:8], s1_opcode_r[7:0]};
      OP_PGHI: page_nxt = {s1_opcode_r[7:0], page_r[7:0]};
      OP_ST: begin
        wv_nxt    = 1'b1;
        wdata_nxt = acc_r;
      end
      OP_SWAP: begin
        acc_nxt   = s1_operand_r;
        wv_nxt    = 1'b1;
        wdata_nxt = acc_r;
      end
      OP_CLR: begin
        acc_nxt  = '0;
        page_nxt = '0;
      end
      OP_HALT: halt_nxt = 1'b1;
      default: begin
        halt_nxt = halt_r;
      end
    endcase
    // Hold the stack unless this instruction really executes
    if (!adv) begin
      stk_ctl.push = 1'b0;
      stk_ctl.pop  = 1'b0;
    end
  end

  dce_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stk_ctl),
    .top_data (stk_top)
  );

  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      flags_r     <= '0;
      prod_lo_r   <= '0;
      prod_hi_r   <= '0;
      page_r      <= '0;
      halt_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        acc_r   <= acc_nxt;
        flags_r <= flags_nxt;
        page_r  <= page_nxt;
        halt_r  <= halt_nxt;
        if (alu_res.prod_we) begin
          prod_lo_r <= alu_res.prod[DW-1:0];
          prod_hi_r <= alu_res.prod[2*DW-1:DW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_pc_r <= new_pc_nxt;
      taken_r  <= taken_nxt;
      skip_r   <= skip_nxt;
      wv_r     <= wv_nxt;
      wdata_r  <= wdata_nxt;
    end
  end

  // State changes only together with the output word, so it drives the port
  assign out_valid        = out_valid_r;
  assign out_acc_value    = acc_r;
  assign out_flag_bits    = flags_r;
  assign out_product_low  = prod_lo_r;
  assign out_product_high = prod_hi_r;
  assign out_page_value   = page_r;
  assign out_new_pc       = new_pc_r;
  assign out_page_changed = taken_r;
  assign out_skip_next    = skip_r;
  assign out_halted       = halt_r;
  assign out_write_valid  = wv_r;
  assign out_write_data   = wdata_r;

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  // A skip and a taken branch never come from the same instruction
  a_skip_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(skip_r && taken_r))
    else $error("skip and branch reported together");

  // Stalled input only while an instruction waits in the input register
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked instruction");

endmodule

// ===== tb/dsp_coprocessor_execute_unit_top_tb.sv =====
`timescale 1ns / 1ps

module dsp_coprocessor_execute_unit_top_tb;
  import dce_pkg::*;

  localparam int unsigned RS_DEPTH = 8;

  // Opcode modifier bits, applied on top of the package patterns
  localparam logic [OW-1:0] OPB_IMM   = 16'h0400;  // operand is the immediate byte
  localparam logic [OW-1:0] OPB_CALL  = 16'h2000;  // jump also pushes the return PC
  localparam logic [OW-1:0] OPB_LONG  = 16'h0200;  // jump target comes from the page
  localparam logic [OW-1:0] OPB_SH1   = 16'h0100;  // shifted A: by 1
  localparam logic [OW-1:0] OPB_SH8   = 16'h0200;  // shifted A: by 8
  localparam logic [OW-1:0] OPB_SH16  = 16'h0300;  // shifted A: by 16
  localparam logic [OW-1:0] OPB_HALT  = 16'hfc00;  // not in the decode table
  localparam logic [OW-1:0] SKIP_ON_C = 16'h0100;
  localparam logic [OW-1:0] SKIP_ON_Z = 16'h0200;
  localparam logic [OW-1:0] SKIP_ON_N = 16'h0300;
  localparam logic [OW-1:0] SKIP_SET  = 16'h0001;
  localparam logic [OW-1:0] MASK_ALL  = 16'hffff;
  localparam int unsigned   NUM_CLASSES = 40;

  typedef struct {
    logic [DW-1:0] acc;
    flags_t        flags;
    logic [DW-1:0] plo;
    logic [DW-1:0] phi;
    logic [PW-1:0] page;
    logic [DW-1:0] npc;
    logic          taken;
    logic          skip;
    logic          halt;
    logic          wv;
    logic [DW-1:0] wdata;
  } exec_word_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [15:0]   in_opcode = '0;
  logic [23:0]   in_operand_value = '0;
  logic [23:0]   in_fetched_pc = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [23:0]   out_acc_value;
  logic [3:0]    out_flag_bits;
  logic [23:0]   out_product_low;
  logic [23:0]   out_product_high;
  logic [15:0]   out_page_value;
  logic [23:0]   out_new_pc;
  logic          out_page_changed;
  logic          out_skip_next;
  logic          out_halted;
  logic          out_write_valid;
  logic [23:0]   out_write_data;

  // Architectural state as this bench tracks it
  logic [DW-1:0] acc_m;
  flags_t        flg_m;
  logic [DW-1:0] plo_m;
  logic [DW-1:0] phi_m;
  logic [PW-1:0] page_m;
  logic [DW-1:0] rstack_m [RS_DEPTH];
  logic          halt_m;

  exec_word_t    exec_results [$];   // predicted output words, oldest first
  int            fail_count = 0;
  int unsigned   idle_pct = 0;       // chance the sender skips a cycle
  int unsigned   stall_pct = 0;      // chance the receiver drops ready
  int unsigned   hold_req = 0;       // long receiver hold-off, in cycles
  int unsigned   hold_left = 0;

  dsp_coprocessor_execute_unit_top #(.STACK_DEPTH(RS_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_operand_value (in_operand_value),
    .in_fetched_pc    (in_fetched_pc),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_acc_value    (out_acc_value),
    .out_flag_bits    (out_flag_bits),
    .out_product_low  (out_product_low),
    .out_product_high (out_product_high),
    .out_page_value   (out_page_value),
    .out_new_pc       (out_new_pc),
    .out_page_changed (out_page_changed),
    .out_skip_next    (out_skip_next),
    .out_halted       (out_halted),
    .out_write_valid  (out_write_valid),
    .out_write_data   (out_write_data)
  );

  always #2 clk = ~clk;

  // Hard stop in case the handshake locks up
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Instruction predictor
  // ---------------------------------------------------------------------

  function automatic logic [DW-1:0] shifted_acc(logic [OW-1:0] op);
    case (op[9:8])
      2'd0: return acc_m;
      2'd1: return {acc_m[22:0], 1'b0};
      2'd2: return {acc_m[15:0], 8'h00};
      default: return {acc_m[7:0], 16'h0000};
    endcase
  endfunction

  task automatic set_nz(input logic [DW-1:0] v);
    flg_m[FLAG_N] = v[23];
    flg_m[FLAG_Z] = (v == '0);
  endtask

  task automatic clear_model;
    acc_m  = '0;
    flg_m  = '0;
    plo_m  = '0;
    phi_m  = '0;
    page_m = '0;
    halt_m = 1'b0;
    for (int i = 0; i < RS_DEPTH; i++) rstack_m[i] = '0;
  endtask

  // Execute one instruction on the tracked state and build the output word.
  task automatic execute_instr(input logic [OW-1:0] op, input logic [DW-1:0] opv,
                               input logic [DW-1:0] pc, output exec_word_t w);
    logic [DW-1:0]      ri, old_a, npc, x, y, sa;
    logic [DW:0]        r;
    logic [2*DW-1:0]    rr;
    logic signed [47:0] ma, mb, mp;
    logic               taken, skip, wv;
    int                 jc;
    int unsigned        k;

    ri    = (op & OPB_IMM) != '0 ? {16'h0000, op[7:0]} : opv;
    old_a = acc_m;
    npc   = pc;
    taken = 1'b0;
    skip  = 1'b0;
    wv    = 1'b0;
    sa    = shifted_acc(op);

    // Conditional jump decode reads the flags from before this instruction
    jc = -1;
    if ((op & MASK_JMP) == PAT_JMP) jc = 1;
    else if ((op & MASK_JMP) == PAT_JZ) jc = flg_m[FLAG_Z];
    else if ((op & MASK_JMP) == PAT_JC) jc = flg_m[FLAG_C];
    else if ((op & MASK_JMP) == PAT_JN) jc = flg_m[FLAG_N];
    else if ((op & MASK_JMP) == PAT_JV) jc = flg_m[FLAG_V];

    if ((op & MASK_GRP) == PAT_NOP) begin
    end else if (jc >= 0) begin
      if (jc == 1) begin
        if ((op & OPB_CALL) != '0) begin
          for (int i = RS_DEPTH - 1; i > 0; i--) rstack_m[i] = rstack_m[i-1];
          rstack_m[0] = pc;
        end
        npc   = (op & OPB_LONG) != '0 ? {page_m, op[7:0]} : {pc[23:8], op[7:0]};
        taken = 1'b1;
      end
    end else if ((op & MASK_GRP) == PAT_LOOP) begin
    end else if ((op & MASK_GRP) == PAT_SKIP) begin
      // op[9:8] picks V, C, Z or N, matching the packed flag positions
      skip = (flg_m[op[9:8]] == op[0]);
    end else if ((op & MASK_GRP) == PAT_RET) begin
      npc = rstack_m[0];
      for (int i = 0; i < RS_DEPTH - 1; i++) rstack_m[i] = rstack_m[i+1];
      rstack_m[RS_DEPTH-1] = '0;
      taken = 1'b1;
    end else if ((op & MASK_GRP) == PAT_INC) begin
    end else if ((op & MASK_ALU) == PAT_CMPR || (op & MASK_ALU) == PAT_CMP) begin
      if ((op & MASK_ALU) == PAT_CMPR) begin
        x = ri; y = sa;
      end else begin
        x = sa; y = ri;
      end
      r = {1'b0, x} - {1'b0, y};
      set_nz(r[23:0]);
      flg_m[FLAG_C] = (x >= y);
    end else if ((op & MASK_IMM) == PAT_SXB) begin
      acc_m = {{16{ri[7]}}, ri[7:0]};
    end else if ((op & MASK_IMM) == PAT_SXW) begin
      acc_m = {{8{ri[15]}}, ri[15:0]};
    end else if ((op & MASK_IMM) == PAT_LD) begin
      acc_m = ri;
    end else if ((op & MASK_IMM) == PAT_LDP) begin
      page_m = ri[15:0];
    end else if ((op & MASK_BYTE) == PAT_PGLO) begin
      page_m[7:0] = op[7:0];
    end else if ((op & MASK_BYTE) == PAT_PGHI) begin
      page_m[15:8] = op[7:0];
    end else if ((op & MASK_ALU) == PAT_ADD) begin
      r     = {1'b0, sa} + {1'b0, ri};
      acc_m = r[23:0];
      set_nz(acc_m);
      flg_m[FLAG_C] = r[24];
      flg_m[FLAG_V] = ~(sa[23] & ri[23]) & (sa[23] ^ r[23]);
    end else if ((op & MASK_ALU) == PAT_SUBR || (op & MASK_ALU) == PAT_SUB) begin
      if ((op & MASK_ALU) == PAT_SUBR) begin
        x = ri; y = sa;
      end else begin
        x = sa; y = ri;
      end
      r     = {1'b0, x} - {1'b0, y};
      acc_m = r[23:0];
      set_nz(acc_m);
      flg_m[FLAG_C] = (x >= y);
      flg_m[FLAG_V] = ~(x[23] & y[23]) & (x[23] ^ r[23]);
    end else if ((op & MASK_IMM) == PAT_MUL) begin
      // Signed 24x24; C and V are left alone
      ma    = {{24{acc_m[23]}}, acc_m};
      mb    = {{24{ri[23]}}, ri};
      mp    = ma * mb;
      plo_m = mp[23:0];
      phi_m = mp[47:24];
      flg_m[FLAG_N] = mp[47];
      flg_m[FLAG_Z] = (mp == '0);
    end else if ((op & MASK_ALU) == PAT_XOR) begin
      acc_m = sa ^ ri;
      set_nz(acc_m);
    end else if ((op & MASK_ALU) == PAT_AND) begin
      acc_m = sa & ri;
      set_nz(acc_m);
    end else if ((op & MASK_ALU) == PAT_OR) begin
      acc_m = sa | ri;
      set_nz(acc_m);
    end else if ((op & MASK_IMM) == PAT_SHR) begin
      acc_m = (ri >= 24) ? '0 : acc_m >> ri;
      set_nz(acc_m);
    end else if ((op & MASK_IMM) == PAT_ASR) begin
      if (ri >= 24) acc_m = {24{acc_m[23]}};
      else acc_m = $signed(acc_m) >>> ri[4:0];
      set_nz(acc_m);
    end else if ((op & MASK_IMM) == PAT_ROR) begin
      k = ri % 24;
      if (k != 0) begin
        rr    = {acc_m, acc_m} >> k;
        acc_m = rr[23:0];
      end
      set_nz(acc_m);
    end else if ((op & MASK_IMM) == PAT_SHL) begin
      acc_m = (ri >= 24) ? '0 : acc_m << ri;
      set_nz(acc_m);
    end else if ((op & MASK_BYTE) == PAT_ST) begin
      wv = 1'b1;
    end else if ((op & MASK_GRP) == PAT_SWAP) begin
      acc_m = opv;
      wv    = 1'b1;
    end else if ((op & MASK_GRP) == PAT_CLR) begin
      acc_m  = '0;
      page_m = '0;
    end else if ((op & MASK_IMM) == PAT_EXT_A || (op & MASK_IMM) == PAT_EXT_B ||
                 (op & MASK_IMM) == PAT_EXT_C || (op & MASK_IMM) == PAT_EXT_D ||
                 op == PAT_EXT_E || (op & MASK_BYTE) == PAT_EXT_F ||
                 (op & MASK_IMM) == PAT_EXT_G || (op & MASK_IMM) == PAT_EXT_H ||
                 (op & MASK_IMM) == PAT_EXT_I) begin
      // external transfers: nothing to do inside the unit
    end else begin
      halt_m = 1'b1;
    end

    w.acc   = acc_m;
    w.flags = flg_m;
    w.plo   = plo_m;
    w.phi   = phi_m;
    w.page  = page_m;
    w.npc   = npc;
    w.taken = taken;
    w.skip  = skip;
    w.halt  = halt_m;
    w.wv    = wv;
    w.wdata = wv ? old_a : '0;
  endtask

  // ---------------------------------------------------------------------
  // Drive and check
  // ---------------------------------------------------------------------

  // Offer one word at a falling edge, hold it until the rising edge that
  // takes it, then predict its result. Returns right after that edge so the
  // next word (or a drop of valid) lands on the following falling edge.
  task automatic issue_instr(input logic [OW-1:0] op, input logic [DW-1:0] opv,
                             input logic [DW-1:0] pc);
    exec_word_t w;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_operand_value <= opv;
    in_fetched_pc    <= pc;
    do @(posedge clk); while (!in_ready);
    execute_instr(op, opv, pc, w);
    exec_results.push_back(w);
  endtask

  // Drop valid and wait until every predicted word has been retired.
  task automatic wait_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (exec_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: random ready, with an optional long hold-off counted here
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [DW-1:0] want,
                             input logic [DW-1:0] got);
    if (got !== want) begin
      $display("%0t ns %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each retired word against the oldest prediction
  always @(posedge clk) begin
    exec_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exec_results.size() == 0) begin
        $display("%0t ns unexpected output word: expected none, actual acc %h",
                 $time, out_acc_value);
        fail_count++;
      end else begin
        want = exec_results.pop_front();
        check_field("acc_value", want.acc, out_acc_value);
        check_field("flag_bits", 24'(want.flags), 24'(out_flag_bits));
        check_field("product_low", want.plo, out_product_low);
        check_field("product_high", want.phi, out_product_high);
        check_field("page_value", 24'(want.page), 24'(out_page_value));
        check_field("new_pc", want.npc, out_new_pc);
        check_field("page_changed", 24'(want.taken), 24'(out_page_changed));
        check_field("skip_next", 24'(want.skip), 24'(out_skip_next));
        check_field("halted", 24'(want.halt), 24'(out_halted));
        check_field("write_valid", 24'(want.wv), 24'(out_write_valid));
        check_field("write_data", want.wdata, out_write_data);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generators
  // ---------------------------------------------------------------------

  // Pick one decoded instruction class and randomize its don't-care bits.
  function automatic logic [OW-1:0] class_opcode(int unsigned k);
    logic [OW-1:0] rnd, pat, msk;
    rnd = 16'($urandom);
    case (k)
      0:  begin pat = PAT_NOP;   msk = MASK_GRP;  end
      1:  begin pat = PAT_JMP;   msk = MASK_JMP;  end
      2:  begin pat = PAT_JZ;    msk = MASK_JMP;  end
      3:  begin pat = PAT_JC;    msk = MASK_JMP;  end
      4:  begin pat = PAT_JN;    msk = MASK_JMP;  end
      5:  begin pat = PAT_JV;    msk = MASK_JMP;  end
      6:  begin pat = PAT_LOOP;  msk = MASK_GRP;  end
      7:  begin pat = PAT_SKIP;  msk = MASK_GRP;  end
      8:  begin pat = PAT_RET;   msk = MASK_GRP;  end
      9:  begin pat = PAT_INC;   msk = MASK_GRP;  end
      10: begin pat = PAT_CMPR;  msk = MASK_ALU;  end
      11: begin pat = PAT_CMP;   msk = MASK_ALU;  end
      12: begin pat = PAT_SXB;   msk = MASK_IMM;  end
      13: begin pat = PAT_SXW;   msk = MASK_IMM;  end
      14: begin pat = PAT_LD;    msk = MASK_IMM;  end
      15: begin pat = PAT_LDP;   msk = MASK_IMM;  end
      16: begin pat = PAT_PGLO;  msk = MASK_BYTE; end
      17: begin pat = PAT_PGHI;  msk = MASK_BYTE; end
      18: begin pat = PAT_ADD;   msk = MASK_ALU;  end
      19: begin pat = PAT_SUBR;  msk = MASK_ALU;  end
      20: begin pat = PAT_SUB;   msk = MASK_ALU;  end
      21: begin pat = PAT_MUL;   msk = MASK_IMM;  end
      22: begin pat = PAT_XOR;   msk = MASK_ALU;  end
      23: begin pat = PAT_AND;   msk = MASK_ALU;  end
      24: begin pat = PAT_OR;    msk = MASK_ALU;  end
      25: begin pat = PAT_SHR;   msk = MASK_IMM;  end
      26: begin pat = PAT_ASR;   msk = MASK_IMM;  end
      27: begin pat = PAT_ROR;   msk = MASK_IMM;  end
      28: begin pat = PAT_SHL;   msk = MASK_IMM;  end
      29: begin pat = PAT_ST;    msk = MASK_BYTE; end
      30: begin pat = PAT_SWAP;  msk = MASK_GRP;  end
      31: begin pat = PAT_CLR;   msk = MASK_GRP;  end
      32: begin pat = PAT_EXT_A; msk = MASK_IMM;  end
      33: begin pat = PAT_EXT_B; msk = MASK_IMM;  end
      34: begin pat = PAT_EXT_C; msk = MASK_IMM;  end
      35: begin pat = PAT_EXT_D; msk = MASK_IMM;  end
      36: begin pat = PAT_EXT_E; msk = MASK_ALL;  end
      37: begin pat = PAT_EXT_F; msk = MASK_BYTE; end
      38: begin pat = PAT_EXT_G; msk = MASK_IMM;  end
      default: begin pat = PAT_EXT_H; msk = MASK_IMM; end
    endcase
    return pat | (rnd & ~msk);
  endfunction

  // Operands lean toward edge values and small shift amounts.
  function automatic logic [DW-1:0] pick_operand;
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return 24'h800000;
      3: return 24'h7fffff;
      4: return 24'($urandom_range(30));
      default: return 24'($urandom);
    endcase
  endfunction

  // A run of one to 10 calls followed by as many returns, at times deep enough to overflow
  task automatic call_ret_burst(output int unsigned count);
    int unsigned n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      issue_instr(PAT_JMP | OPB_CALL | (16'($urandom) & (OPB_LONG | 16'h00ff)),
                  pick_operand(), 24'($urandom));
    for (int i = 0; i < n; i++)
      issue_instr(PAT_RET | (16'($urandom) & ~MASK_GRP), pick_operand(), 24'($urandom));
    count = 2 * n;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_directed;
    idle_pct  = 0;
    stall_pct = 0;
    // return on an empty stack pops zero
    issue_instr(PAT_RET, 24'h000000, 24'h123456);
    issue_instr(PAT_LD | OPB_IMM | 16'h00ff, 24'h000000, 24'h000001);
    issue_instr(PAT_LD, 24'h7fffff, 24'h000002);
    // signed overflow into bit 23
    issue_instr(PAT_ADD, 24'h000001, 24'h000003);
    // swap writes the old accumulator out
    issue_instr(PAT_SWAP | 16'h0012, 24'hffffff, 24'h000004);
    // carry out of bit 23, zero result
    issue_instr(PAT_ADD | OPB_IMM | 16'h0001, 24'h000000, 24'h000005);
    // borrow
    issue_instr(PAT_SUB | OPB_IMM | 16'h0001, 24'h000000, 24'h000006);
    // shifted A loses its upper bits before the ALU
    issue_instr(PAT_SUBR | OPB_SH16, 24'h000000, 24'h000007);
    issue_instr(PAT_CMP | OPB_IMM | OPB_SH1 | 16'h0080, 24'h000000, 24'h000008);
    issue_instr(PAT_CMPR | OPB_SH8, 24'hffffff, 24'h000009);
    issue_instr(PAT_SXB | OPB_IMM | 16'h0080, 24'h000000, 24'h00000a);
    issue_instr(PAT_SXW, 24'h3c8000, 24'h00000b);
    issue_instr(PAT_MUL, 24'h800000, 24'h00000c);
    // zero product sets Z, keeps C and V
    issue_instr(PAT_MUL | OPB_IMM, 24'h000000, 24'h00000d);
    issue_instr(PAT_LD, 24'h800001, 24'h00000e);
    // arithmetic shift by 24 or more fills with the sign
    issue_instr(PAT_ASR | OPB_IMM | 16'h0018, 24'h000000, 24'h00000f);
    issue_instr(PAT_LD, 24'h800001, 24'h000010);
    // rotate by 25 acts as rotate by 1
    issue_instr(PAT_ROR | OPB_IMM | 16'h0019, 24'h000000, 24'h000011);
    issue_instr(PAT_SHL, 24'd23, 24'h000012);
    // logical shift by a huge amount gives zero
    issue_instr(PAT_SHR, 24'hffffff, 24'h000013);
    issue_instr(PAT_XOR | OPB_SH1, 24'h555555, 24'h000014);
    issue_instr(PAT_LDP, 24'h12abcd, 24'h000015);
    issue_instr(PAT_PGLO | 16'h005a, 24'h000000, 24'h000016);
    issue_instr(PAT_PGHI | 16'h00a5, 24'h000000, 24'h000017);
    issue_instr(PAT_JZ | OPB_CALL | OPB_LONG | 16'h0033, 24'h000000, 24'habcdef);
    issue_instr(PAT_JMP | 16'h0077, 24'h000000, 24'hfedcba);
    issue_instr(PAT_SKIP | SKIP_ON_Z | SKIP_SET, 24'h000000, 24'h000018);
    issue_instr(PAT_SKIP | SKIP_ON_N, 24'h000000, 24'h000019);
    issue_instr(PAT_RET, 24'h000000, 24'h00001a);
    issue_instr(PAT_ST | 16'h0005, 24'h000000, 24'h00001b);
    // clear hits only A and the page
    issue_instr(PAT_CLR, 24'hffffff, 24'h00001c);
    issue_instr(PAT_EXT_E, 24'hffffff, 24'hffffff);
    issue_instr(PAT_SKIP | SKIP_ON_C | SKIP_SET, 24'h000000, 24'h00001d);
    issue_instr(PAT_JC | 16'h0042, 24'h000000, 24'h00001e);
  endtask

  task automatic test_random_phase(input int unsigned n, input int unsigned idle,
                                   input int unsigned stall);
    int unsigned sent, b;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        call_ret_burst(b);
        sent += b;
      end else begin
        issue_instr(class_opcode($urandom_range(NUM_CLASSES - 1)), pick_operand(),
                    24'($urandom));
        sent++;
      end
    end
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // unit fills and drops in_ready.
  task automatic test_backpressure;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 300;
    for (int i = 0; i < 60; i++)
      issue_instr(class_opcode($urandom_range(NUM_CLASSES - 1)), pick_operand(),
                  24'($urandom));
  endtask

  // Stop sending until every result is back, then resume.
  task automatic test_drain_pause;
    idle_pct  = 9;
    stall_pct = 9;
    for (int i = 0; i < 30; i++)
      issue_instr(class_opcode($urandom_range(NUM_CLASSES - 1)), pick_operand(),
                  24'($urandom));
    wait_drained();
    for (int i = 0; i < 30; i++)
      issue_instr(class_opcode($urandom_range(NUM_CLASSES - 1)), pick_operand(),
                  24'($urandom));
  endtask

  // Halt is sticky, so it comes last; afterwards throw raw opcodes at it.
  task automatic test_halt_and_noise;
    idle_pct  = 9;
    stall_pct = 9;
    issue_instr(OPB_HALT, 24'h000000, 24'h000100);
    issue_instr(PAT_ADD | OPB_IMM | 16'h0003, 24'h000000, 24'h000101);
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(1) == 0)
        issue_instr(16'($urandom), 24'($urandom), 24'($urandom));
      else
        issue_instr(class_opcode($urandom_range(NUM_CLASSES - 1)), pick_operand(),
                    24'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clear_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phase(270, 0, 0);
    test_random_phase(270, 52, 0);
    test_random_phase(270, 0, 52);
    test_random_phase(270, 9, 9);
    test_backpressure();
    test_drain_pause();
    test_halt_and_noise();

    // Let the two-stage pipe settle, then look for anything stray
    wait_drained();
    repeat (8) @(negedge clk);
    if (exec_results.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
